/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mcs_pkg.sv */
// Package for the monotone cubic spline coefficient block.
// Constants, codes, arithmetic request type and saturation helpers. No dependencies.
package mcs_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 24;
	localparam int UP_SHIFT   = (OUT_FRAC_BITS >= IN_FRAC_BITS) ? (OUT_FRAC_BITS - IN_FRAC_BITS) : 0;
	localparam int DOWN_SHIFT = (OUT_FRAC_BITS < IN_FRAC_BITS) ? (IN_FRAC_BITS - OUT_FRAC_BITS) : 0;

	localparam int CNT_W = 8;
	// bit counts per operation: divide numerators are left aligned in 128 bits
	localparam logic [CNT_W-1:0] NB_SEC  = CNT_W'(33 + OUT_FRAC_BITS);
	localparam logic [CNT_W-1:0] NB_QUAD = CNT_W'(51 + IN_FRAC_BITS);
	localparam logic [CNT_W-1:0] NB_CUBE = CNT_W'(51 + 2 * IN_FRAC_BITS);
	localparam logic [CNT_W-1:0] NB_TQ   = CNT_W'(128);
	localparam logic [CNT_W-1:0] NB_TE   = CNT_W'(86);
	localparam logic [CNT_W-1:0] NB_M48  = CNT_W'(48);
	localparam logic [CNT_W-1:0] NB_M33  = CNT_W'(33);
	localparam logic [CNT_W-1:0] NB_M34  = CNT_W'(34);
	localparam logic [CNT_W-1:0] NB_M32  = CNT_W'(32);

	typedef enum logic [1:0] {ST_OK, ST_FEW, ST_ORDER, ST_SAT} status_t;

	typedef enum logic {ARITH_MUL, ARITH_DIV} arith_op_t;

	typedef struct packed {
		logic             start;
		arith_op_t        op;
		logic [CNT_W-1:0] nbits;
	} arith_req_t;

	typedef struct packed {
		logic        sat;
		logic [47:0] val;
	} sat_t;

	// truncated magnitude to signed 48 bits with clamp
	function automatic sat_t sat48(input logic neg, input logic [127:0] q);
		sat_t r;
		logic [47:0] cap;
		logic [47:0] mg;
		cap = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		if (q > {80'd0, cap}) begin
			mg = cap;
			r.sat = 1'b1;
		end else begin
			mg = q[47:0];
			r.sat = 1'b0;
		end
		r.val = neg ? (~mg + 48'd1) : mg;
		return r;
	endfunction

	function automatic logic [47:0] mag48(input logic [47:0] v);
		return v[47] ? (~v + 48'd1) : v;
	endfunction

endpackage

/* rtl/mcs_pt_if.sv */
// Input point channel: valid/ready plus one point word.
// No dependencies.
interface mcs_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_value;
	logic               last_point;

	modport source(output valid, x_coord, y_value, last_point, input ready);
	modport sink(input valid, x_coord, y_value, last_point, output ready);
endinterface

/* rtl/mcs_seg_if.sv */
// Output segment channel: valid/ready plus one coefficient word.
// No dependencies.
interface mcs_seg_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] value_coeff;
	logic signed [47:0] slope_coeff;
	logic signed [47:0] quad_coeff;
	logic signed [47:0] cubic_coeff;
	logic               segment_last;
	logic [1:0]         status;

	modport source(output valid, value_coeff, slope_coeff, quad_coeff, cubic_coeff,
		segment_last, status, input ready);
	modport sink(input valid, value_coeff, slope_coeff, quad_coeff, cubic_coeff,
		segment_last, status, output ready);
endinterface

/* rtl/monotone_cubic_spline_coeffs.sv */
// Monotone cubic Hermite (PCHIP) segment coefficients from a stream of points.
// Depends on mcs_pkg, mcs_pt_if, mcs_seg_if, mcs_arith.
// Shared multiply/divide unit, one bit per cycle; a zero tangent skips
//   its tangent steps. A new point waits in S_IDLE until the last one is done.
// Ordering error or single-point curve: flag word via S_EMIT; output stalls hold it.
// Async active-low reset clears the curve window and the output register.
module monotone_cubic_spline_coeffs (
	input  logic      clk,
	input  logic      arst_n,
	mcs_pt_if.sink    pt,
	mcs_seg_if.source seg
);
	import mcs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SEC, S_MUL_AA, S_MUL_P, S_MUL_D1, S_MUL_D2, S_DIV_Q, S_DIV_E,
		S_TFIN, S_SEG, S_QUAD, S_SQR, S_CUBE, S_EMIT
	} state_t;

	state_t state_q;

	// curve window
	logic [31:0] prior_x_q, prior_y_q, start_y_q, prior_step_q;
	logic [47:0] prior_secant_q, prior_tangent_q;
	logic [1:0]  points_q;
	logic        secant_sat_q, tangent_sat_q;

	// current point
	logic [31:0] in_x_q, in_y_q, step_q;
	logic        in_last_q, rise_neg_q;
	logic [47:0] sec_q;
	logic        sec_sat_q;

	// tangent work
	logic [127:0] prod_q;
	logic [83:0]  d_q;
	logic [47:0]  q_q, mid_q;

	// segment under construction
	logic [31:0] seg_y_q, seg_step_q;
	logic [47:0] seg_t0_q, seg_t1_q, seg_sec_q;
	logic        seg_sat_q, seg_last_q, seg_more_q;
	logic [47:0] quad_q, cubic_q;
	logic        quad_sat_q, cubic_sat_q;
	logic        flag_q;
	status_t     flag_status_q;

	// output word register
	logic        out_valid_q;
	logic [47:0] out_value_q, out_slope_q, out_quad_q, out_cubic_q;
	logic        out_last_q;
	status_t     out_status_q;

	// shared unit
	arith_req_t   req_q;
	logic [127:0] opa_q;
	logic [84:0]  opb_q;
	logic         ar_done;
	logic [127:0] ar_res;
	logic [84:0]  ar_rem;

	mcs_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_q),
		.opa   (opa_q),
		.opb   (opb_q),
		.done  (ar_done),
		.res   (ar_res),
		.rem   (ar_rem)
	);

	logic        take, out_free, order_bad;
	logic [32:0] rise, rise_mag, step_w;
	sat_t        sres, qres, cres, vres;
	logic        tzero;
	logic [47:0] a0, a1;
	logic [32:0] h_sum;
	logic [33:0] h_a, h_b;
	logic [83:0] dsum;
	logic [85:0] rem3;
	logic [47:0] tsum;
	logic [50:0] sx, t0x, t1x, lin, bend, lin_mag, bend_mag;
	logic [32:0] y_mag;

	always_comb begin
		take      = pt.valid && (state_q == S_IDLE);
		out_free  = !out_valid_q || seg.ready;
		order_bad = $signed(pt.x_coord) <= $signed(prior_x_q);
		rise      = {pt.y_value[31], pt.y_value} - {prior_y_q[31], prior_y_q};
		rise_mag  = rise[32] ? (~rise + 33'd1) : rise;
		step_w    = {pt.x_coord[31], pt.x_coord} - {prior_x_q[31], prior_x_q};
		sres      = sat48(rise_neg_q, ar_res);
		// tangent is zero on a sign change or flat secant
		tzero     = (prior_secant_q == 48'd0) || (sres.val == 48'd0)
			|| (prior_secant_q[47] != sres.val[47]);
		a0        = mag48(prior_secant_q);
		a1        = mag48(sec_q);
		h_sum     = {1'b0, prior_step_q} + {1'b0, step_q};
		h_a       = {2'b0, prior_step_q} + {1'b0, step_q, 1'b0};
		h_b       = {1'b0, prior_step_q, 1'b0} + {2'b0, step_q};
		dsum      = d_q + ar_res[83:0];
		rem3      = {1'b0, ar_rem} + {ar_rem, 1'b0};
		tsum      = {q_q[46:0], 1'b0} + q_q + ar_res[47:0];
		// segment shape terms
		sx        = {{3{seg_sec_q[47]}}, seg_sec_q};
		t0x       = {{3{seg_t0_q[47]}}, seg_t0_q};
		t1x       = {{3{seg_t1_q[47]}}, seg_t1_q};
		lin       = (sx + {sx[49:0], 1'b0}) - {t0x[49:0], 1'b0} - t1x;
		bend      = t0x + t1x - {sx[49:0], 1'b0};
		lin_mag   = lin[50] ? (~lin + 51'd1) : lin;
		bend_mag  = bend[50] ? (~bend + 51'd1) : bend;
		qres      = sat48(lin[50], ar_res);
		cres      = sat48(bend[50], ar_res);
		y_mag     = seg_y_q[31] ? (~{1'b1, seg_y_q} + 33'd1) : {1'b0, seg_y_q};
		vres      = sat48(seg_y_q[31], ({95'd0, y_mag} << UP_SHIFT) >> DOWN_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			prior_x_q       <= '0;
			prior_y_q       <= '0;
			start_y_q       <= '0;
			prior_step_q    <= '0;
			prior_secant_q  <= '0;
			prior_tangent_q <= '0;
			points_q        <= '0;
			secant_sat_q    <= 1'b0;
			tangent_sat_q   <= 1'b0;
			in_x_q          <= '0;
			in_y_q          <= '0;
			step_q          <= '0;
			in_last_q       <= 1'b0;
			rise_neg_q      <= 1'b0;
			sec_q           <= '0;
			sec_sat_q       <= 1'b0;
			prod_q          <= '0;
			d_q             <= '0;
			q_q             <= '0;
			mid_q           <= '0;
			seg_y_q         <= '0;
			seg_step_q      <= '0;
			seg_t0_q        <= '0;
			seg_t1_q        <= '0;
			seg_sec_q       <= '0;
			seg_sat_q       <= 1'b0;
			seg_last_q      <= 1'b0;
			seg_more_q      <= 1'b0;
			quad_q          <= '0;
			cubic_q         <= '0;
			quad_sat_q      <= 1'b0;
			cubic_sat_q     <= 1'b0;
			flag_q          <= 1'b0;
			flag_status_q   <= ST_OK;
			out_valid_q     <= 1'b0;
			out_value_q     <= '0;
			out_slope_q     <= '0;
			out_quad_q      <= '0;
			out_cubic_q     <= '0;
			out_last_q      <= 1'b0;
			out_status_q    <= ST_OK;
			req_q           <= '{start: 1'b0, op: ARITH_MUL, nbits: '0};
			opa_q           <= '0;
			opb_q           <= '0;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && seg.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (take) begin
						in_x_q    <= pt.x_coord;
						in_y_q    <= pt.y_value;
						in_last_q <= pt.last_point;
						if (points_q == 2'd0) begin
							if (pt.last_point) begin
								// lone point
								flag_q        <= 1'b1;
								flag_status_q <= ST_FEW;
								seg_last_q    <= 1'b1;
								seg_more_q    <= 1'b0;
								state_q       <= S_EMIT;
							end else begin
								prior_x_q <= pt.x_coord;
								prior_y_q <= pt.y_value;
								points_q  <= 2'd1;
							end
						end else if (order_bad) begin
							// drop the curve, this point may start the next one
							flag_q        <= 1'b1;
							flag_status_q <= ST_ORDER;
							seg_last_q    <= pt.last_point;
							seg_more_q    <= 1'b0;
							prior_x_q     <= pt.x_coord;
							prior_y_q     <= pt.y_value;
							points_q      <= pt.last_point ? 2'd0 : 2'd1;
							state_q       <= S_EMIT;
						end else begin
							step_q     <= step_w[31:0];
							rise_neg_q <= rise[32];
							req_q      <= '{start: 1'b1, op: ARITH_DIV, nbits: NB_SEC};
							opa_q      <= {rise_mag, 95'd0};
							opb_q      <= {53'd0, step_w[31:0]};
							state_q    <= S_SEC;
						end
					end
				end
				S_SEC: begin
					if (ar_done) begin
						sec_q     <= sres.val;
						sec_sat_q <= sres.sat;
						if (points_q == 2'd1) begin
							if (in_last_q) begin
								// two-point curve: straight segment
								flag_q     <= 1'b0;
								seg_y_q    <= prior_y_q;
								seg_t0_q   <= sres.val;
								seg_t1_q   <= sres.val;
								seg_sec_q  <= sres.val;
								seg_step_q <= step_q;
								seg_sat_q  <= sres.sat;
								seg_last_q <= 1'b1;
								seg_more_q <= 1'b0;
								points_q   <= 2'd0;
								state_q    <= S_SEG;
							end else begin
								start_y_q       <= prior_y_q;
								prior_tangent_q <= sres.val;
								tangent_sat_q   <= sres.sat;
								prior_step_q    <= step_q;
								prior_secant_q  <= sres.val;
								secant_sat_q    <= sres.sat;
								prior_x_q       <= in_x_q;
								prior_y_q       <= in_y_q;
								points_q        <= 2'd2;
								state_q         <= S_IDLE;
							end
						end else if (tzero) begin
							mid_q   <= '0;
							state_q <= S_TFIN;
						end else begin
							req_q   <= '{start: 1'b1, op: ARITH_MUL, nbits: NB_M48};
							opa_q   <= {80'd0, a0};
							opb_q   <= {37'd0, mag48(sres.val)};
							state_q <= S_MUL_AA;
						end
					end
				end
				S_MUL_AA: begin
					if (ar_done) begin
						req_q   <= '{start: 1'b1, op: ARITH_MUL, nbits: NB_M33};
						opa_q   <= ar_res;
						opb_q   <= {52'd0, h_sum};
						state_q <= S_MUL_P;
					end
				end
				S_MUL_P: begin
					if (ar_done) begin
						prod_q  <= ar_res;
						req_q   <= '{start: 1'b1, op: ARITH_MUL, nbits: NB_M34};
						opa_q   <= {80'd0, a1};
						opb_q   <= {51'd0, h_a};
						state_q <= S_MUL_D1;
					end
				end
				S_MUL_D1: begin
					if (ar_done) begin
						d_q     <= ar_res[83:0];
						req_q   <= '{start: 1'b1, op: ARITH_MUL, nbits: NB_M34};
						opa_q   <= {80'd0, a0};
						opb_q   <= {51'd0, h_b};
						state_q <= S_MUL_D2;
					end
				end
				S_MUL_D2: begin
					if (ar_done) begin
						d_q     <= dsum;
						req_q   <= '{start: 1'b1, op: ARITH_DIV, nbits: NB_TQ};
						opa_q   <= prod_q;
						opb_q   <= {1'b0, dsum};
						state_q <= S_DIV_Q;
					end
				end
				S_DIV_Q: begin
					if (ar_done) begin
						q_q     <= ar_res[47:0];
						// 3*remainder / d gives the last correction to 3q
						req_q   <= '{start: 1'b1, op: ARITH_DIV, nbits: NB_TE};
						opa_q   <= {rem3, 42'd0};
						opb_q   <= {1'b0, d_q};
						state_q <= S_DIV_E;
					end
				end
				S_DIV_E: begin
					if (ar_done) begin
						mid_q   <= prior_secant_q[47] ? (~tsum + 48'd1) : tsum;
						state_q <= S_TFIN;
					end
				end
				S_TFIN: begin
					// segment ending at the middle point; window slides
					flag_q          <= 1'b0;
					seg_y_q         <= start_y_q;
					seg_t0_q        <= prior_tangent_q;
					seg_t1_q        <= mid_q;
					seg_sec_q       <= prior_secant_q;
					seg_step_q      <= prior_step_q;
					seg_sat_q       <= tangent_sat_q || secant_sat_q || sec_sat_q;
					seg_last_q      <= 1'b0;
					seg_more_q      <= in_last_q;
					start_y_q       <= prior_y_q;
					prior_tangent_q <= mid_q;
					tangent_sat_q   <= secant_sat_q || sec_sat_q;
					prior_step_q    <= step_q;
					prior_secant_q  <= sec_q;
					secant_sat_q    <= sec_sat_q;
					prior_x_q       <= in_x_q;
					prior_y_q       <= in_y_q;
					points_q        <= in_last_q ? 2'd0 : 2'd2;
					state_q         <= S_SEG;
				end
				S_SEG: begin
					req_q   <= '{start: 1'b1, op: ARITH_DIV, nbits: NB_QUAD};
					opa_q   <= {lin_mag, 77'd0};
					opb_q   <= {53'd0, seg_step_q};
					state_q <= S_QUAD;
				end
				S_QUAD: begin
					if (ar_done) begin
						quad_q     <= qres.val;
						quad_sat_q <= qres.sat;
						req_q      <= '{start: 1'b1, op: ARITH_MUL, nbits: NB_M32};
						opa_q      <= {96'd0, seg_step_q};
						opb_q      <= {53'd0, seg_step_q};
						state_q    <= S_SQR;
					end
				end
				S_SQR: begin
					if (ar_done) begin
						req_q   <= '{start: 1'b1, op: ARITH_DIV, nbits: NB_CUBE};
						opa_q   <= {bend_mag, 77'd0};
						opb_q   <= {21'd0, ar_res[63:0]};
						state_q <= S_CUBE;
					end
				end
				S_CUBE: begin
					if (ar_done) begin
						cubic_q     <= cres.val;
						cubic_sat_q <= cres.sat;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= seg_last_q;
						if (flag_q) begin
							out_value_q  <= '0;
							out_slope_q  <= '0;
							out_quad_q   <= '0;
							out_cubic_q  <= '0;
							out_status_q <= flag_status_q;
						end else begin
							out_value_q  <= vres.val;
							out_slope_q  <= seg_t0_q;
							out_quad_q   <= quad_q;
							out_cubic_q  <= cubic_q;
							out_status_q <= (seg_sat_q || quad_sat_q || cubic_sat_q || vres.sat)
								? ST_SAT : ST_OK;
						end
						if (seg_more_q) begin
							// closing segment from the window just slid in
							seg_y_q    <= start_y_q;
							seg_t0_q   <= prior_tangent_q;
							seg_t1_q   <= prior_secant_q;
							seg_sec_q  <= prior_secant_q;
							seg_step_q <= prior_step_q;
							seg_sat_q  <= tangent_sat_q;
							seg_last_q <= 1'b1;
							seg_more_q <= 1'b0;
							state_q    <= S_SEG;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pt.ready         = (state_q == S_IDLE);
	assign seg.valid        = out_valid_q;
	assign seg.value_coeff  = out_value_q;
	assign seg.slope_coeff  = out_slope_q;
	assign seg.quad_coeff   = out_quad_q;
	assign seg.cubic_coeff  = out_cubic_q;
	assign seg.segment_last = out_last_q;
	assign seg.status       = out_status_q;
endmodule

/* rtl/mcs_arith.sv */
// Shared iterative unit: shift-add multiply and restoring divide, one bit per cycle.
// Depends on mcs_pkg.
module mcs_arith (
	input  logic               clk,
	input  logic               arst_n,
	input  mcs_pkg::arith_req_t req,
	input  logic [127:0]       opa,
	input  logic [84:0]        opb,
	output logic               done,
	output logic [127:0]       res,
	output logic [84:0]        rem
);
	import mcs_pkg::*;

	logic [127:0]     acc_q;
	logic [127:0]     sh_q;
	logic [84:0]      rm_q;
	logic [83:0]      dv_q;
	logic [CNT_W-1:0] cnt_q;
	arith_op_t        op_q;
	logic             busy_q;
	logic             done_q;

	logic [84:0]  r2;
	logic         ge;
	logic [84:0]  diff;
	logic [127:0] sum;

	always_comb begin
		r2   = {rm_q[83:0], sh_q[127]};
		ge   = r2 >= {1'b0, dv_q};
		diff = r2 - {1'b0, dv_q};
		sum  = acc_q + sh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ARITH_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= opa;
			rm_q  <= (req.op == ARITH_DIV) ? 85'd0 : opb;
			dv_q  <= opb[83:0];
		end else if (busy_q) begin
			if (op_q == ARITH_MUL) begin
				if (rm_q[0])
					acc_q <= sum;
				sh_q <= {sh_q[126:0], 1'b0};
				rm_q <= {1'b0, rm_q[84:1]};
			end else begin
				sh_q  <= {sh_q[126:0], 1'b0};
				acc_q <= {acc_q[126:0], ge};
				rm_q  <= ge ? diff : r2;
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
	assign rem  = rm_q;
endmodule

/* rtl/mcs_checker.sv */
// Port-level checks for the spline coefficient block, bound to the top level.
// Depends on mcs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pt_valid,
	input logic        pt_ready,
	input logic        seg_valid,
	input logic        seg_ready,
	input logic [47:0] value_coeff,
	input logic [47:0] slope_coeff,
	input logic [47:0] quad_coeff,
	input logic [47:0] cubic_coeff,
	input logic        segment_last,
	input logic [1:0]  status
);
	import mcs_pkg::*;

	// ready only drops right after a point was taken
	`ASSERT_CLK(a_busy_after_take, clk, arst_n, $fell(pt_ready) |-> $past(pt_valid),
		"ready fell with no point")
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		seg_valid && !seg_ready |=> seg_valid && $stable(value_coeff) && $stable(status),
		"stalled word changed")
	`ASSERT_CLK(a_few_zero, clk, arst_n,
		seg_valid && status == ST_FEW |-> segment_last && value_coeff == 48'd0
		&& slope_coeff == 48'd0, "bad lone point word")
	`ASSERT_CLK(a_order_zero, clk, arst_n,
		seg_valid && status == ST_ORDER |-> value_coeff == 48'd0 && quad_coeff == 48'd0
		&& cubic_coeff == 48'd0, "bad order error word")
	`ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !seg_valid, "word valid in reset")
endmodule

bind monotone_cubic_spline_coeffs mcs_checker u_mcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pt_valid    (pt.valid),
	.pt_ready    (pt.ready),
	.seg_valid   (seg.valid),
	.seg_ready   (seg.ready),
	.value_coeff (seg.value_coeff),
	.slope_coeff (seg.slope_coeff),
	.quad_coeff  (seg.quad_coeff),
	.cubic_coeff (seg.cubic_coeff),
	.segment_last(seg.segment_last),
	.status      (seg.status)
);
